@@ rtl/rrts_pkg.sv @@
// Shared types and codes for the round-robin tick scheduler.
package rrts_pkg;

   // Default configuration of the job ring
   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 16;

   // Request kinds
   localparam logic REQ_ADD  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Result status codes
   typedef enum logic [2:0] {
      STATUS_ADDED = 3'd0,
      STATUS_RAN   = 3'd1,
      STATUS_DONE  = 3'd2,
      STATUS_IDLE  = 3'd3,
      STATUS_FULL  = 3'd4,
      STATUS_ZERO  = 3'd5
   } rrts_status_type;

   // Control sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } rrts_state_type;

   // Request transaction payload
   typedef struct packed {
      logic        req_type;
      logic [15:0] job_id;
      logic [15:0] ticks_needed;
   } rrts_req_type;

   // Result transaction payload
   typedef struct packed {
      rrts_status_type status;
      logic [15:0]     served_id;
      logic [15:0]     ticks_run;
      logic [4:0]      jobs_queued;
   } rrts_rsp_type;

endpackage

@@ rtl/round_robin_tick_scheduler_top.sv @@
// Round-robin one-tick scheduler over a ring of job records held in one memory.
//
// Jobs live in a ring of QUEUE_DEPTH records (identifier, ticks needed, ticks run)
// in a single synchronous RAM with a registered read. An add transaction
// writes the tail record in the cycle it is accepted and its result is ready the
// next cycle. A tick transaction on a non-empty queue issues a read of the head
// record when accepted; the cycle after, the returned record is advanced by one
// tick and either retired or written back at the tail, and the result is loaded.
// A tick on an empty queue answers without a RAM read. A new request is taken
// once no tick is in progress and the result register is empty or being emptied
// in the same cycle. Records are not cleared at reset; only occupied slots are read.
module round_robin_tick_scheduler_top #(
   parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH,
   parameter int TIME_BITS   = rrts_pkg::TIME_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rrts_pkg::rrts_req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rrts_pkg::rrts_rsp_type rsp_payload
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [15:0]          id;
      logic [TIME_BITS-1:0] need;
      logic [TIME_BITS-1:0] ran;
   } rec_type;

   // Registers
   rrts_pkg::rrts_state_type state_ff, state_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rrts_pkg::rrts_rsp_type   rsp_ff, rsp_in;
   rec_type                  rd_data_ff;

   // Memory port controls
   rec_type                  mem [QUEUE_DEPTH];
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   rec_type                  mem_wdata;
   logic                     rd_en;

   // Working values
   logic [31:0]              need_wide;
   logic [TIME_BITS-1:0]     add_need;
   logic [TIME_BITS-1:0]     ran_next;
   logic [31:0]              ran_wide;
   logic [31:0]              count_wide;
   logic                     load_rsp;
   logic                     accept;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
      next_slot = (s == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   assign need_wide = 32'(req_payload.ticks_needed);
   assign add_need  = need_wide[TIME_BITS-1:0];
   assign ran_next  = rd_data_ff.ran + 1'b1;
   assign ran_wide  = 32'(ran_next);

   // Input taken only between ticks and when the result register frees up
   assign req_ready = (state_ff == rrts_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Job ring memory: synchronous write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrts_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // Sequencer: next state, pointer updates, memory controls and result load
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = tail_ff;
      mem_wdata    = rd_data_ff;
      rd_en        = 1'b0;
      load_rsp     = 1'b0;
      count_wide   = '0;

      case (state_ff)
         rrts_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_payload.req_type == rrts_pkg::REQ_ADD) begin
                  load_rsp            = 1'b1;
                  rsp_in.served_id    = req_payload.job_id;
                  rsp_in.ticks_run    = '0;
                  if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                     rsp_in.status = rrts_pkg::STATUS_FULL;
                  end else if (add_need == '0) begin
                     rsp_in.status = rrts_pkg::STATUS_ZERO;
                  end else begin
                     mem_we         = 1'b1;
                     mem_wdata.id   = req_payload.job_id;
                     mem_wdata.need = add_need;
                     mem_wdata.ran  = '0;
                     tail_in        = next_slot(tail_ff);
                     count_in       = count_ff + 1'b1;
                     rsp_in.status  = rrts_pkg::STATUS_ADDED;
                  end
               end else if (count_ff == '0) begin
                  load_rsp         = 1'b1;
                  rsp_in.status    = rrts_pkg::STATUS_IDLE;
                  rsp_in.served_id = '0;
                  rsp_in.ticks_run = '0;
               end else begin
                  // fetch head record; finished next cycle
                  rd_en    = 1'b1;
                  state_in = rrts_pkg::ST_EXEC;
               end
            end
         end
         rrts_pkg::ST_EXEC: begin
            // head record is back: count the tick, retire or requeue
            load_rsp         = 1'b1;
            head_in          = next_slot(head_ff);
            rsp_in.served_id = rd_data_ff.id;
            rsp_in.ticks_run = ran_wide[15:0];
            if (ran_next >= rd_data_ff.need) begin
               count_in      = count_ff - 1'b1;
               rsp_in.status = rrts_pkg::STATUS_DONE;
            end else begin
               mem_we        = 1'b1;
               mem_wdata.ran = ran_next;
               tail_in       = next_slot(tail_ff);
               rsp_in.status = rrts_pkg::STATUS_RAN;
            end
            state_in = rrts_pkg::ST_IDLE;
         end
         default: begin
            state_in = rrts_pkg::ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         count_wide         = 32'(count_in);
         rsp_in.jobs_queued = count_wide[4:0];
         rsp_valid_in       = 1'b1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Occupancy never exceeds the ring size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("job count above queue depth");

   // Empty or full ring has head and tail on the same slot
   a_ring_ends: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(QUEUE_DEPTH)) |-> head_ff == tail_ff)
      else $error("head and tail disagree with job count");

   // Result register is free whenever a tick completes
   a_exec_rsp_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == rrts_pkg::ST_EXEC |-> !rsp_valid_ff)
      else $error("tick completed over a pending result");

   // A tick on a non-empty ring goes to the write-back cycle
   a_tick_fetch: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.req_type == rrts_pkg::REQ_TICK && count_ff != '0)
      |=> state_ff == rrts_pkg::ST_EXEC && rsp_valid_ff == 1'b0)
      else $error("tick did not fetch head record");

   // Write-back is followed by idle and always produces a result
   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == rrts_pkg::ST_EXEC |=> state_ff == rrts_pkg::ST_IDLE && rsp_valid_ff)
      else $error("write-back did not complete");

endmodule

@@ dv/rrts_checker.sv @@
// Checker for the round-robin tick scheduler: predicts each result and compares.
`timescale 1ns / 1ps

module rrts_checker #(
   parameter int QUEUE_DEPTH = rrts_pkg::QUEUE_DEPTH,
   parameter int TIME_BITS   = rrts_pkg::TIME_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  rrts_pkg::rrts_req_type req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rrts_pkg::rrts_rsp_type rsp_payload,
   output int                     fail_count,
   output int                     pending_count,
   output int                     results_checked,
   output logic [7:0]             statuses_seen
);

   // Shadow copy of the job ring
   logic [15:0] ring_id   [QUEUE_DEPTH];
   logic [31:0] ring_need [QUEUE_DEPTH];
   logic [31:0] ring_ran  [QUEUE_DEPTH];
   int unsigned ring_head;
   int unsigned ring_tail;
   int unsigned ring_count;

   // Results predicted but not yet seen on the result channel
   rrts_pkg::rrts_rsp_type expected_rsp_q[$];

   int         mismatch_total = 0;
   int         checked_total  = 0;
   logic [7:0] seen_mask      = '0;

   assign fail_count    = mismatch_total;
   assign statuses_seen = seen_mask;

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatch_total++;
   endtask

   // Advance the shadow ring by one request and return the result it should give
   function automatic rrts_pkg::rrts_rsp_type schedule_step(
      input rrts_pkg::rrts_req_type req);
      logic [31:0]            mask;
      logic [31:0]            need;
      logic [31:0]            ran;
      logic [15:0]            head_id;
      logic [31:0]            head_need;
      int unsigned            h;
      rrts_pkg::rrts_rsp_type res;
      mask = (TIME_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TIME_BITS) - 32'd1);
      need = {16'd0, req.ticks_needed} & mask;
      res  = '0;
      if (req.req_type == rrts_pkg::REQ_ADD) begin
         res.served_id = req.job_id;
         if (ring_count >= QUEUE_DEPTH) begin
            res.status = rrts_pkg::STATUS_FULL;
         end else if (need == 32'd0) begin
            res.status = rrts_pkg::STATUS_ZERO;
         end else begin
            ring_id[ring_tail]   = req.job_id;
            ring_need[ring_tail] = need;
            ring_ran[ring_tail]  = 32'd0;
            ring_tail  = (ring_tail + 1) % QUEUE_DEPTH;
            ring_count = ring_count + 1;
            res.status = rrts_pkg::STATUS_ADDED;
         end
      end else if (ring_count == 0) begin
         res.status = rrts_pkg::STATUS_IDLE;
      end else begin
         // Pop the head, charge one tick, retire or requeue at the tail
         h         = ring_head;
         head_id   = ring_id[h];
         head_need = ring_need[h];
         ran       = (ring_ran[h] + 32'd1) & mask;
         ring_head = (h + 1) % QUEUE_DEPTH;
         res.served_id = head_id;
         res.ticks_run = ran[15:0];
         if (ran >= head_need) begin
            ring_count = ring_count - 1;
            res.status = rrts_pkg::STATUS_DONE;
         end else begin
            ring_id[ring_tail]   = head_id;
            ring_need[ring_tail] = head_need;
            ring_ran[ring_tail]  = ran;
            ring_tail  = (ring_tail + 1) % QUEUE_DEPTH;
            res.status = rrts_pkg::STATUS_RAN;
         end
      end
      res.jobs_queued = 5'(ring_count);
      return res;
   endfunction

   // Watch both channels at each edge
   always @(posedge clock) begin : monitor_blk
      rrts_pkg::rrts_rsp_type want;
      rrts_pkg::rrts_rsp_type got;
      if (reset) begin
         ring_head  = 0;
         ring_tail  = 0;
         ring_count = 0;
         expected_rsp_q.delete();
      end else begin
         // Result side first: a result never belongs to a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (expected_rsp_q.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: status %0d id 0x%0h",
                                         got.status, got.served_id));
            end else begin
               want = expected_rsp_q.pop_front();
               checked_total++;
               if (got.status !== want.status)
                  report_mismatch($sformatf("result %0d status got %0d expected %0d",
                                            checked_total, got.status, want.status));
               if (got.served_id !== want.served_id)
                  report_mismatch($sformatf("result %0d served_id got 0x%0h expected 0x%0h",
                                            checked_total, got.served_id, want.served_id));
               if (got.ticks_run !== want.ticks_run)
                  report_mismatch($sformatf("result %0d ticks_run got %0d expected %0d",
                                            checked_total, got.ticks_run, want.ticks_run));
               if (got.jobs_queued !== want.jobs_queued)
                  report_mismatch($sformatf("result %0d jobs_queued got %0d expected %0d",
                                            checked_total, got.jobs_queued,
                                            want.jobs_queued));
            end
            if (!$isunknown(got.status))
               seen_mask[got.status] = 1'b1;
         end
         // Request side: predict the transaction just taken
         if (req_valid && req_ready)
            expected_rsp_q.push_back(schedule_step(req_payload));
      end
      pending_count   <= expected_rsp_q.size();
      results_checked <= checked_total;
   end

endmodule

@@ dv/round_robin_tick_scheduler_top_tb.sv @@
// Testbench top for the round-robin tick scheduler: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module round_robin_tick_scheduler_top_tb;

   localparam int RANDOM_ITEMS = 850;
   localparam int PHASE_LEN    = 40;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   rrts_pkg::rrts_req_type req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rrts_pkg::rrts_rsp_type rsp_payload;

   int         fail_count;
   int         pending_count;
   int         results_checked;
   logic [7:0] statuses_seen;

   int add_total  = 0;
   int tick_total = 0;
   bit sender_no_gaps = 0;

   // Clock: 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   round_robin_tick_scheduler_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   rrts_checker sched_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .statuses_seen   (statuses_seen)
   );

   // Idle length between transactions: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   // Offer one request and hold it until the block takes it
   task automatic send_request(input logic kind, input logic [15:0] id,
                               input logic [15:0] ticks);
      int unsigned gap;
      gap = sender_no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_payload.req_type <= kind;
      req_payload.job_id   <= id;
      req_payload.ticks_needed <= ticks;
      do
         @(posedge clock);
      while (!req_ready);
      if (kind == rrts_pkg::REQ_ADD)
         add_total++;
      else
         tick_total++;
   endtask

   // Receiver: random stalls, one long hold-off to back up the input side
   initial begin : receiver_blk
      int unsigned stall_len;
      int unsigned run_len;
      int unsigned r;
      bit          long_hold_done;
      long_hold_done = 0;
      @(negedge reset);
      forever begin
         r = $urandom_range(99);
         if (r < 55)
            stall_len = 0;
         else if (r < 90)
            stall_len = $urandom_range(3, 1);
         else
            stall_len = $urandom_range(40, 10);
         if (!long_hold_done && results_checked >= 120) begin
            stall_len      = 300;
            long_hold_done = 1;
         end
         r = $urandom_range(99);
         run_len = (r < 85) ? $urandom_range(6, 1) : $urandom_range(100, 40);
         if (stall_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall_len) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat (run_len) @(posedge clock);
      end
   end

   // Stimulus and verdict
   initial begin : stimulus_blk
      logic [31:0] rnd;
      logic [15:0] rand_id;
      logic [15:0] rand_ticks;
      logic        kind;
      int unsigned add_pct;
      int unsigned r;
      add_pct = 50;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty queue, zero-tick refusal, finish, fill to full, full refusal, ticks on the full ring
      send_request(rrts_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF);
      send_request(rrts_pkg::REQ_ADD,  16'h1234, 16'h0000);
      send_request(rrts_pkg::REQ_ADD,  16'h0000, 16'h0001);
      send_request(rrts_pkg::REQ_TICK, 16'h0000, 16'h0000);
      send_request(rrts_pkg::REQ_ADD,  16'hFFFF, 16'hFFFF);
      for (int i = 1; i < rrts_pkg::QUEUE_DEPTH; i++)
         send_request(rrts_pkg::REQ_ADD, 16'(16'hA000 + i), 16'(i % 3 + 1));
      send_request(rrts_pkg::REQ_ADD,  16'h5555, 16'h0003);
      send_request(rrts_pkg::REQ_ADD,  16'hAAAA, 16'h0000);
      send_request(rrts_pkg::REQ_TICK, 16'h0000, 16'h0000);
      send_request(rrts_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF);
      send_request(rrts_pkg::REQ_TICK, 16'h0000, 16'h0000);

      // Random: phases lean toward filling, balance or draining the ring
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_LEN == 0) begin
            r = $urandom_range(2);
            add_pct        = (r == 0) ? 80 : (r == 1) ? 55 : 25;
            sender_no_gaps = ($urandom_range(99) < 25);
         end
         rnd     = $urandom();
         rand_id = rnd[15:0];
         kind    = ($urandom_range(99) < add_pct) ? rrts_pkg::REQ_ADD : rrts_pkg::REQ_TICK;
         r       = $urandom_range(99);
         if (kind == rrts_pkg::REQ_TICK) begin
            rnd        = $urandom();
            rand_ticks = rnd[15:0];
         end else if (r < 4) begin
            rand_ticks = 16'h0000;
         end else if (r < 5) begin
            rnd        = $urandom();
            rand_ticks = rnd[15:0];
         end else if (r < 80) begin
            rand_ticks = 16'($urandom_range(6, 1));
         end else begin
            rand_ticks = 16'($urandom_range(40, 7));
         end
         send_request(kind, rand_id, rand_ticks);
      end
      req_valid <= 1'b0;

      // Drain: wait for every expected result, then idle before the verdict
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Run covered %0d requests (%0d adds, %0d ticks), %0d results checked",
               add_total + tick_total, add_total, tick_total, results_checked);
      $display("Status codes returned (one bit per code, code 0 rightmost): %b",
               statuses_seen);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("Watchdog expired with %0d results outstanding", pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ files.f @@
rtl/rrts_pkg.sv
rtl/round_robin_tick_scheduler_top.sv
dv/rrts_checker.sv
dv/round_robin_tick_scheduler_top_tb.sv
